FILE: sv/flow_connection_table_unit_defines.svh
// assertion macros for the flow connection table
// included by the modules that carry concurrent checks; no other dependencies
`ifndef FLOW_CONNECTION_TABLE_UNIT_DEFINES_SVH
`define FLOW_CONNECTION_TABLE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define FCT_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("flow table check failed");
`define FCT_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("flow table check failed");
`else
`define FCT_ASSERT(name, clk, rst_n, prop)
`define FCT_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

FILE: sv/fct_pkg.sv
// shared types and codes of the flow connection table
// no dependencies
package fct_pkg;

    localparam int DEF_TABLE_DEPTH = 256;
    localparam int IDX_W = 16;

    localparam logic [2:0] REQ_GET      = 3'd0;
    localparam logic [2:0] REQ_FIND     = 3'd1;
    localparam logic [2:0] REQ_UPDATE   = 3'd2;
    localparam logic [2:0] REQ_CLASSIFY = 3'd3;
    localparam logic [2:0] REQ_BLOCK    = 3'd4;
    localparam logic [2:0] REQ_CLOSE    = 3'd5;
    localparam logic [2:0] REQ_CLEANUP  = 3'd6;
    localparam logic [2:0] REQ_CLEAR    = 3'd7;

    localparam logic [2:0] ST_NEW = 3'd0;
    localparam logic [2:0] ST_EST = 3'd1;
    localparam logic [2:0] ST_CLS = 3'd2;
    localparam logic [2:0] ST_BLK = 3'd3;
    localparam logic [2:0] ST_CLO = 3'd4;

    localparam logic CFG_MAX_ENTRIES = 1'b0;
    localparam logic CFG_TIMEOUT     = 1'b1;

    localparam logic [8:0]  RST_MAX_ENTRIES = 9'd256;
    localparam logic [31:0] RST_TIMEOUT     = 32'd60000;

    typedef struct packed {
        logic [31:0] sip;
        logic [31:0] dip;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
    } t_key;

    typedef struct packed {
        t_key        key;
        logic [2:0]  status;
        logic [3:0]  cls;
        logic        drop;
        logic [31:0] seen_tick;
        logic [31:0] pkt_in;
        logic [31:0] pkt_out;
        logic [47:0] byte_in;
        logic [47:0] byte_out;
    } t_entry;

    // running results of one pass over the table
    typedef struct packed {
        logic             exact_hit;
        logic [IDX_W-1:0] exact_idx;
        logic             rev_hit;
        logic [IDX_W-1:0] rev_idx;
        logic             old_hit;
        logic [IDX_W-1:0] old_idx;
        logic [31:0]      old_age;
        logic             free_hit;
        logic [IDX_W-1:0] free_idx;
    } t_scan;

endpackage

FILE: sv/fct_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module fct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/fct_scan.sv
// search unit: follows the entries streamed out of the table ram and keeps
// first exact / reversed match, oldest live entry and lowest free slot; uses fct_pkg
module fct_scan import fct_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_strobe,
    input  logic [IDX_W-1:0] i_idx,
    input  logic             i_vld,
    input  t_entry           i_ent,
    input  t_key             i_key,
    input  logic [31:0]      i_now,
    input  logic [31:0]      i_timeout,
    output t_scan            o_res,
    output logic             o_remove
);

    t_scan       r_res;
    t_scan       n_res;
    t_key        w_rev;
    logic [31:0] w_age;

    always_comb begin
        w_rev       = i_key;
        w_rev.sip   = i_key.dip;
        w_rev.dip   = i_key.sip;
        w_rev.sport = i_key.dport;
        w_rev.dport = i_key.sport;
        w_age       = i_now - i_ent.seen_tick;
    end

    always_comb begin
        n_res = r_res;
        if (i_start) begin
            n_res = '0;
        end else if (i_strobe) begin
            if (i_vld) begin
                if (!r_res.exact_hit && i_ent.key == i_key) begin
                    n_res.exact_hit = 1'b1;
                    n_res.exact_idx = i_idx;
                end
                if (!r_res.rev_hit && i_ent.key == w_rev) begin
                    n_res.rev_hit = 1'b1;
                    n_res.rev_idx = i_idx;
                end
                // strict compare keeps the lowest index on ties
                if (!r_res.old_hit || w_age > r_res.old_age) begin
                    n_res.old_hit = 1'b1;
                    n_res.old_idx = i_idx;
                    n_res.old_age = w_age;
                end
            end else if (!r_res.free_hit) begin
                n_res.free_hit = 1'b1;
                n_res.free_idx = i_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else begin
            r_res <= n_res;
        end
    end

    assign o_res    = r_res;
    assign o_remove = i_strobe && i_vld && (w_age >= i_timeout || i_ent.status == ST_CLO);

endmodule

FILE: sv/flow_connection_table_unit.sv
// flow connection table top level: request sequencer, valid bits, counters
// depends on fct_pkg, fct_ram, fct_scan and flow_connection_table_unit_defines.svh
//
// Usage: one request enters on the input channel (i_valid / o_ready) and
// gives exactly one result on the output channel (o_valid / i_ready).
// Registers max_entries (index 0) and stale_timeout (index 1) are written
// through i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle.
// Entries live in one ram with a registered read; valid bits are
// flops. A request is taken only while the sequencer is idle.
// Update, classify and block go from the accepting edge through read and
// modify states to the posted result; a bad slot goes straight there, as
// does clear. Get-or-create, find, close and cleanup walk the ram one entry
// a cycle, then evaluate: a miss or a cleanup goes to the result, a created
// entry is written first and a hit is read back and modified. The next
// request is taken only after the result is posted, so one lookup runs at a time.
// Reset empties the table, zeroes counters and loads the register defaults;
// no clearing pass is needed. When the receiver stalls, the result waits in
// the output register and the next request may already be taken and run; it
// then holds before its result until the register frees.
module flow_connection_table_unit import fct_pkg::*; #(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_req_type,
    input  logic [31:0] i_src_ip,
    input  logic [31:0] i_dst_ip,
    input  logic [15:0] i_src_port,
    input  logic [15:0] i_dst_port,
    input  logic [7:0]  i_protocol,
    input  logic [7:0]  i_entry_index,
    input  logic [15:0] i_packet_size,
    input  logic        i_outbound,
    input  logic [3:0]  i_app_class,
    input  logic [31:0] i_now_tick,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_found,
    output logic [7:0]  o_result_index,
    output logic [2:0]  o_conn_state,
    output logic [3:0]  o_entry_app,
    output logic        o_drop_mark,
    output logic [31:0] o_dir_packets,
    output logic [47:0] o_dir_bytes,
    output logic [8:0]  o_active_count,
    output logic [31:0] o_total_seen,
    output logic [31:0] o_classified_total,
    output logic [31:0] o_blocked_total,
    output logic [8:0]  o_removed_count
);

`include "flow_connection_table_unit_defines.svh"

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = $bits(t_entry);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_EVAL, S_CREATE, S_RD, S_MOD, S_DONE
    } t_state;

    t_state r_state;

    logic [8:0]  r_max;
    logic [31:0] r_timeout;

    logic [2:0]  r_req;
    t_key        r_key;
    logic [15:0] r_psize;
    logic        r_obd;
    logic [3:0]  r_app;
    logic [31:0] r_now;
    logic [IW-1:0] r_idx;

    logic [TABLE_DEPTH-1:0] r_valid;
    logic [CW-1:0] r_live;
    logic [31:0]   r_created;
    logic [31:0]   r_classified;
    logic [31:0]   r_blocked;

    logic [CW-1:0] r_addr;
    logic          r_chk;
    logic [IW-1:0] r_chk_idx;

    // working result
    logic          r_rf;
    logic [IW-1:0] r_ri;
    logic [2:0]    r_rs;
    logic [3:0]    r_ra;
    logic          r_rd;
    logic [31:0]   r_rpk;
    logic [47:0]   r_rby;
    logic [CW-1:0] r_rrem;

    logic        r_out_valid;
    logic        r_o_found;
    logic [7:0]  r_o_index;
    logic [2:0]  r_o_state;
    logic [3:0]  r_o_app;
    logic        r_o_drop;
    logic [31:0] r_o_pk;
    logic [47:0] r_o_by;
    logic [8:0]  r_o_active;
    logic [31:0] r_o_seen;
    logic [31:0] r_o_cls;
    logic [31:0] r_o_blk;
    logic [8:0]  r_o_rem;

    logic          w_accept;
    logic          w_issue;
    logic          w_scan_start;
    t_scan         w_scan;
    logic          w_remove;
    t_entry        w_rdata;
    logic [EW-1:0] w_rdata_raw;
    logic          w_we;
    logic [IW-1:0] w_waddr;
    t_entry        w_wdata;
    logic [IW-1:0] w_raddr;
    logic [31:0]   w_cap;
    logic          w_evict;
    logic [IW-1:0] w_old;
    logic [IW-1:0] w_free;
    logic [IW-1:0] w_slot;
    logic          w_bad_slot;
    logic [IW-1:0] w_in_idx;
    t_entry        w_mod;
    logic [31:0]   w_pk_new;
    logic [47:0]   w_by_new;
    logic          w_out_free;
    t_key          w_in_key;

    assign w_accept   = i_valid && o_ready;
    assign o_ready    = (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_ready;
    assign w_issue    = (r_state == S_SCAN) && (r_addr < CW'(TABLE_DEPTH));
    assign w_scan_start = w_accept;
    assign w_in_idx   = IW'(i_entry_index);
    assign w_bad_slot = (32'(i_entry_index) >= 32'(TABLE_DEPTH)) || !r_valid[w_in_idx];
    assign w_rdata    = t_entry'(w_rdata_raw);
    assign w_raddr    = (r_state == S_SCAN) ? r_addr[IW-1:0] : r_idx;
    assign w_old      = IW'(w_scan.old_idx);
    assign w_free     = IW'(w_scan.free_idx);

    always_comb begin
        w_in_key.sip   = i_src_ip;
        w_in_key.dip   = i_dst_ip;
        w_in_key.sport = i_src_port;
        w_in_key.dport = i_dst_port;
        w_in_key.proto = i_protocol;
    end

    // capacity: 0 acts as 1, above the table acts as the table
    always_comb begin
        if (r_max == 9'd0) begin
            w_cap = 32'd1;
        end else if (32'(r_max) > 32'(TABLE_DEPTH)) begin
            w_cap = 32'(TABLE_DEPTH);
        end else begin
            w_cap = 32'(r_max);
        end
        w_evict = (32'(r_live) >= w_cap) && w_scan.old_hit;
        if (w_evict && (!w_scan.free_hit || w_old < w_free)) begin
            w_slot = w_old;
        end else begin
            w_slot = w_free;
        end
    end

    // read-modify of one entry
    always_comb begin
        w_mod = w_rdata;
        w_pk_new = (r_obd ? w_rdata.pkt_out : w_rdata.pkt_in) + 32'd1;
        w_by_new = (r_obd ? w_rdata.byte_out : w_rdata.byte_in) + 48'(r_psize);
        unique case (r_req)
            REQ_UPDATE: begin
                if (r_obd) begin
                    w_mod.pkt_out  = w_pk_new;
                    w_mod.byte_out = w_by_new;
                end else begin
                    w_mod.pkt_in  = w_pk_new;
                    w_mod.byte_in = w_by_new;
                end
                w_mod.seen_tick = r_now;
                if (w_rdata.status == ST_NEW) begin
                    w_mod.status = ST_EST;
                end
            end
            REQ_CLASSIFY: begin
                w_mod.cls = r_app;
                if (w_rdata.status != ST_BLK && w_rdata.status != ST_CLO) begin
                    w_mod.status = ST_CLS;
                end
            end
            REQ_BLOCK: begin
                w_mod.status = ST_BLK;
                w_mod.drop   = 1'b1;
            end
            REQ_CLOSE: begin
                w_mod.status = ST_CLO;
            end
            default: begin
                w_mod = w_rdata;
            end
        endcase
    end

    always_comb begin
        w_wdata = w_mod;
        w_waddr = r_idx;
        w_we    = 1'b0;
        if (r_state == S_CREATE) begin
            w_we            = 1'b1;
            w_waddr         = w_slot;
            w_wdata         = '0;
            w_wdata.key     = r_key;
            w_wdata.status  = ST_NEW;
            w_wdata.seen_tick = r_now;
        end else if (r_state == S_MOD) begin
            w_we = (r_req == REQ_UPDATE) || (r_req == REQ_CLASSIFY) ||
                   (r_req == REQ_BLOCK) || (r_req == REQ_CLOSE);
        end
    end

    fct_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_raw)
    );

    fct_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_scan_start),
        .i_strobe  (r_chk),
        .i_idx     (IDX_W'(r_chk_idx)),
        .i_vld     (r_valid[r_chk_idx]),
        .i_ent     (w_rdata),
        .i_key     (r_key),
        .i_now     (r_now),
        .i_timeout (r_timeout),
        .o_res     (w_scan),
        .o_remove  (w_remove)
    );

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max     <= RST_MAX_ENTRIES;
            r_timeout <= RST_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MAX_ENTRIES: r_max     <= i_cfg_data[8:0];
                CFG_TIMEOUT:     r_timeout <= i_cfg_data;
                default:         r_timeout <= r_timeout;
            endcase
        end
    end

    // request latch
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req   <= i_req_type;
            r_key   <= w_in_key;
            r_psize <= i_packet_size;
            r_obd   <= i_outbound;
            r_app   <= i_app_class;
            r_now   <= i_now_tick;
        end
    end

    // sequencer, table bookkeeping and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_live       <= '0;
            r_created    <= '0;
            r_classified <= '0;
            r_blocked    <= '0;
            r_addr       <= '0;
            r_chk        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            r_chk     <= w_issue;
            r_chk_idx <= r_addr[IW-1:0];
            if (w_issue) begin
                r_addr <= r_addr + CW'(1);
            end
            if (w_remove && r_req == REQ_CLEANUP) begin
                r_valid[r_chk_idx] <= 1'b0;
                r_live <= r_live - CW'(1);
                r_rrem <= r_rrem + CW'(1);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_rf   <= 1'b0;
                        r_ri   <= '0;
                        r_rs   <= '0;
                        r_ra   <= '0;
                        r_rd   <= 1'b0;
                        r_rpk  <= '0;
                        r_rby  <= '0;
                        r_rrem <= '0;
                        r_addr <= '0;
                        r_idx  <= w_in_idx;
                        unique case (i_req_type)
                            REQ_UPDATE, REQ_CLASSIFY, REQ_BLOCK: begin
                                r_state <= w_bad_slot ? S_DONE : S_RD;
                            end
                            REQ_CLEAR: begin
                                r_valid      <= '0;
                                r_live       <= '0;
                                r_created    <= '0;
                                r_classified <= '0;
                                r_blocked    <= '0;
                                r_state      <= S_DONE;
                            end
                            default: begin
                                r_state <= S_SCAN;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_chk && r_chk_idx == IW'(TABLE_DEPTH - 1)) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    priority if (r_req == REQ_CLEANUP) begin
                        r_state <= S_DONE;
                    end else if (w_scan.exact_hit) begin
                        r_idx   <= IW'(w_scan.exact_idx);
                        r_state <= S_RD;
                    end else if (r_req == REQ_GET) begin
                        r_state <= S_CREATE;
                    end else if (w_scan.rev_hit) begin
                        r_idx   <= IW'(w_scan.rev_idx);
                        r_state <= S_RD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_CREATE: begin
                    // an evicted slot that is reused is simply set again
                    if (w_evict && w_old != w_slot) begin
                        r_valid[w_old] <= 1'b0;
                    end
                    r_valid[w_slot] <= 1'b1;
                    if (!w_evict) begin
                        r_live <= r_live + CW'(1);
                    end
                    r_created <= r_created + 32'd1;
                    r_rf      <= 1'b1;
                    r_ri      <= w_slot;
                    r_rs      <= ST_NEW;
                    r_state   <= S_DONE;
                end
                S_RD: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    if (r_req == REQ_CLASSIFY && w_rdata.cls == 4'd0 && r_app != 4'd0) begin
                        r_classified <= r_classified + 32'd1;
                    end
                    if (r_req == REQ_BLOCK && w_rdata.status != ST_BLK) begin
                        r_blocked <= r_blocked + 32'd1;
                    end
                    if (r_req == REQ_UPDATE) begin
                        r_rpk <= w_pk_new;
                        r_rby <= w_by_new;
                    end
                    r_rf    <= 1'b1;
                    r_ri    <= r_idx;
                    r_rs    <= w_mod.status;
                    r_ra    <= w_mod.cls;
                    r_rd    <= w_mod.drop;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_o_found  <= r_rf;
            r_o_index  <= 8'(r_ri);
            r_o_state  <= r_rs;
            r_o_app    <= r_ra;
            r_o_drop   <= r_rd;
            r_o_pk     <= r_rpk;
            r_o_by     <= r_rby;
            r_o_active <= 9'(r_live);
            r_o_seen   <= r_created;
            r_o_cls    <= r_classified;
            r_o_blk    <= r_blocked;
            r_o_rem    <= 9'(r_rrem);
        end
    end

    assign o_valid            = r_out_valid;
    assign o_found            = r_o_found;
    assign o_result_index     = r_o_index;
    assign o_conn_state       = r_o_state;
    assign o_entry_app        = r_o_app;
    assign o_drop_mark        = r_o_drop;
    assign o_dir_packets      = r_o_pk;
    assign o_dir_bytes        = r_o_by;
    assign o_active_count     = r_o_active;
    assign o_total_seen       = r_o_seen;
    assign o_classified_total = r_o_cls;
    assign o_blocked_total    = r_o_blk;
    assign o_removed_count    = r_o_rem;

    `FCT_ASSERT(a_live_bound, i_clk, i_rst_n, 32'(r_live) <= 32'(TABLE_DEPTH))
    `FCT_ASSERT(a_accept_leaves_idle, i_clk, i_rst_n, w_accept |=> r_state != S_IDLE)
    `FCT_ASSERT(a_create_has_slot, i_clk, i_rst_n,
        r_state == S_CREATE |-> (w_evict || w_scan.free_hit))
    `FCT_ASSERT(a_result_from_done, i_clk, i_rst_n,
        $rose(r_out_valid) |-> $past(r_state == S_DONE))

endmodule
